// ===== src/ihpq_pkg.sv =====
// ----------------------------------------------------------------------------
// ihpq_pkg
// Shared types, sizes, codes and the priority compare for the indexed heap.
// ----------------------------------------------------------------------------
package ihpq_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_SPACE = 256;
  localparam int ID_W     = 8;
  localparam int PRI_W    = 32;
  localparam int FUNC_W   = 3;
  localparam int CNT_W    = 7;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int MAP_W    = $clog2(ID_SPACE);

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT   = 3'd0,
    FN_EXTRACT  = 3'd1,
    FN_PEEK     = 3'd2,
    FN_CONTAINS = 3'd3,
    FN_UPDATE   = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_RANGE  = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_ABSENT = 3'd4
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [PRI_W-1:0] pri;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    set_status;
    status_t st_code;
    logic    set_present;
    logic    ins_new;
    logic    old_rd;
    logic    up_rd;
    logic    up_move;
    logic    place;
    logic    l_rd;
    logic    l_cmp;
    logic    r_rd;
    logic    r_cmp;
    logic    dn_move;
    logic    top_take;
    logic    extract;
    logic    last_take;
    logic    out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic in_range;
    logic id_valid;
    logic mov_above;
    logic s_zero;
    logic l_ok;
    logic r_ok;
    logic best_child;
    logic count_one;
    logic out_free;
  } stat_t;

  // true when priority a belongs above priority b
  function automatic logic ranks_above(logic signed [PRI_W-1:0] a,
                                       logic signed [PRI_W-1:0] b,
                                       logic min_mode);
    logic r;
    r = min_mode ? (a < b) : (a > b);
    return r;
  endfunction

endpackage

// ===== src/ihpq_ram.sv =====
// ----------------------------------------------------------------------------
// ihpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ihpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ihpq_dp.sv =====
// ----------------------------------------------------------------------------
// ihpq_dp
// Heap datapath: slot RAM, position map RAM, valid bits, hole/sift registers,
// result and output registers.
// ----------------------------------------------------------------------------
module ihpq_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  ihpq_pkg::cmd_t                     cmd,
  output ihpq_pkg::stat_t                    st,
  input  logic [ihpq_pkg::ID_W-1:0]          item_id,
  input  logic signed [ihpq_pkg::PRI_W-1:0]  in_priority,
  input  logic                               cfg_we,
  input  logic                               cfg_mode,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [2:0]                         status,
  output logic [ihpq_pkg::ID_W-1:0]          out_id,
  output logic signed [ihpq_pkg::PRI_W-1:0]  out_priority,
  output logic                               present,
  output logic [ihpq_pkg::CNT_W-1:0]         count
);

  localparam int SW = ihpq_pkg::SLOT_W;
  localparam int EW = $bits(ihpq_pkg::entry_t);

  logic                          min_mode;
  logic [ihpq_pkg::CNT_W-1:0]    entry_count;
  logic [ihpq_pkg::ID_SPACE-1:0] id_valid;
  logic [SW-1:0]                 s;
  ihpq_pkg::entry_t              mov;
  logic                          best_sel;
  logic [SW-1:0]                 best_idx;
  ihpq_pkg::entry_t              best;
  logic [2:0]                    res_status;
  logic [ihpq_pkg::ID_W-1:0]     res_id;
  logic [ihpq_pkg::PRI_W-1:0]    res_pri;
  logic                          res_present;

  logic                          heap_we;
  logic [SW-1:0]                 heap_waddr;
  ihpq_pkg::entry_t              heap_wdata;
  logic [SW-1:0]                 heap_raddr;
  logic [EW-1:0]                 heap_rraw;
  ihpq_pkg::entry_t              rd;
  logic                          map_we;
  logic [ihpq_pkg::MAP_W-1:0]    map_waddr;
  logic [SW-1:0]                 pos_rdata;

  logic [SW+1:0]                 l_idx;
  logic [SW+1:0]                 r_idx;
  logic [SW-1:0]                 parent;
  logic [SW-1:0]                 last;
  logic [ihpq_pkg::MAP_W-1:0]    in_idx;
  logic signed [ihpq_pkg::PRI_W-1:0] cmp_ref;

  assign rd      = ihpq_pkg::entry_t'(heap_rraw);
  assign in_idx  = item_id[ihpq_pkg::MAP_W-1:0];
  assign l_idx   = {1'b0, s, 1'b1};
  assign r_idx   = l_idx + (SW+2)'(1);
  assign parent  = (s - SW'(1)) >> 1;
  assign last    = SW'(entry_count - ihpq_pkg::CNT_W'(1));
  assign cmp_ref = best_sel ? best.pri : mov.pri;

  // status back to the controller
  always_comb begin
    st.full       = (32'(entry_count) >= ihpq_pkg::CAPACITY);
    st.empty      = (entry_count == '0);
    st.in_range   = (32'(item_id) < ihpq_pkg::ID_SPACE);
    st.id_valid   = id_valid[in_idx];
    st.mov_above  = ihpq_pkg::ranks_above(mov.pri, rd.pri, min_mode);
    st.s_zero     = (s == '0);
    st.l_ok       = (l_idx < (SW+2)'(entry_count));
    st.r_ok       = (r_idx < (SW+2)'(entry_count));
    st.best_child = best_sel;
    st.count_one  = (entry_count == ihpq_pkg::CNT_W'(1));
    st.out_free   = !out_valid || !out_stall;
  end

  // heap read address
  always_comb begin
    heap_raddr = '0;
    if (cmd.old_rd) begin
      heap_raddr = pos_rdata;
    end else if (cmd.up_rd) begin
      heap_raddr = parent;
    end else if (cmd.l_rd) begin
      heap_raddr = l_idx[SW-1:0];
    end else if (cmd.r_rd) begin
      heap_raddr = r_idx[SW-1:0];
    end else if (cmd.extract) begin
      heap_raddr = last;
    end
  end

  // hole fill: parent moves down, best child moves up, or the mover lands
  always_comb begin
    heap_we    = cmd.up_move || cmd.dn_move || cmd.place;
    heap_waddr = s;
    heap_wdata = mov;
    if (cmd.up_move) begin
      heap_wdata = rd;
    end else if (cmd.dn_move) begin
      heap_wdata = best;
    end
    map_we    = heap_we;
    map_waddr = heap_wdata.id[ihpq_pkg::MAP_W-1:0];
  end

  ihpq_ram #(.WIDTH(EW), .DEPTH(ihpq_pkg::CAPACITY)) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rraw)
  );

  ihpq_ram #(.WIDTH(SW), .DEPTH(ihpq_pkg::ID_SPACE)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (s),
    .raddr (in_idx),
    .rdata (pos_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_mode    <= 1'b1;
      entry_count <= '0;
      id_valid    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we && entry_count == '0) begin
        min_mode <= cfg_mode;
      end
      if (cmd.ins_new) begin
        entry_count      <= entry_count + ihpq_pkg::CNT_W'(1);
        id_valid[in_idx] <= 1'b1;
      end
      if (cmd.extract) begin
        entry_count <= entry_count - ihpq_pkg::CNT_W'(1);
        id_valid[rd.id[ihpq_pkg::MAP_W-1:0]] <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mov.id      <= item_id;
      mov.pri     <= in_priority;
      res_id      <= '0;
      res_pri     <= '0;
    end
    // early answers are decided at accept time, otherwise start from ok
    if (cmd.load || cmd.set_status) begin
      res_status <= cmd.set_status ? cmd.st_code : ihpq_pkg::ST_OK;
    end
    if (cmd.load || cmd.set_present) begin
      res_present <= cmd.set_present && id_valid[in_idx];
    end
    if (cmd.ins_new) begin
      s <= entry_count[SW-1:0];
    end
    if (cmd.old_rd) begin
      s <= pos_rdata;
    end
    if (cmd.up_move) begin
      s <= parent;
    end
    if (cmd.l_cmp) begin
      best_sel <= ihpq_pkg::ranks_above(rd.pri, mov.pri, min_mode);
      best_idx <= l_idx[SW-1:0];
      best     <= rd;
    end
    if (cmd.r_cmp && ihpq_pkg::ranks_above(rd.pri, cmp_ref, min_mode)) begin
      best_sel <= 1'b1;
      best_idx <= (l_idx[SW-1:0] + SW'(1));
      best     <= rd;
    end
    if (cmd.dn_move) begin
      s <= best_idx;
    end
    if (cmd.top_take) begin
      res_id  <= rd.id;
      res_pri <= rd.pri;
    end
    if (cmd.last_take) begin
      mov <= rd;
      s   <= '0;
    end
    if (cmd.out_load) begin
      status       <= res_status;
      out_id       <= res_id;
      out_priority <= res_pri;
      present      <= res_present;
      count        <= entry_count;
    end
  end

endmodule

// ===== src/ihpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// ihpq_ctrl
// Operation sequencer: decodes the function, walks sift-up / sift-down.
// ----------------------------------------------------------------------------
module ihpq_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [ihpq_pkg::FUNC_W-1:0]   func,
  input  ihpq_pkg::stat_t               st,
  output ihpq_pkg::cmd_t                cmd,
  output logic                          idle
);

  typedef enum logic [3:0] {
    S_IDLE, S_POS_WAIT, S_OLD_WAIT, S_UP_CHK, S_UP_CMP, S_PLACE,
    S_DN_L, S_DN_LW, S_DN_RW, S_DN_DEC, S_TOP_PK, S_TOP_EX,
    S_EX_LAST, S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  assign idle = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_FIN;
          case (func)
            ihpq_pkg::FN_INSERT: begin
              if (st.full) begin
                cmd.set_status = 1'b1;
                cmd.st_code    = ihpq_pkg::ST_FULL;
              end else if (!st.in_range) begin
                cmd.set_status = 1'b1;
                cmd.st_code    = ihpq_pkg::ST_RANGE;
              end else if (st.id_valid) begin
                state_next = S_POS_WAIT;
              end else begin
                cmd.ins_new = 1'b1;
                state_next  = S_UP_CHK;
              end
            end
            ihpq_pkg::FN_EXTRACT, ihpq_pkg::FN_PEEK: begin
              if (st.empty) begin
                cmd.set_status = 1'b1;
                cmd.st_code    = ihpq_pkg::ST_EMPTY;
              end else begin
                state_next = (func == ihpq_pkg::FN_PEEK) ? S_TOP_PK : S_TOP_EX;
              end
            end
            ihpq_pkg::FN_CONTAINS: begin
              if (!st.in_range) begin
                cmd.set_status = 1'b1;
                cmd.st_code    = ihpq_pkg::ST_RANGE;
              end else begin
                cmd.set_present = 1'b1;
              end
            end
            ihpq_pkg::FN_UPDATE: begin
              if (!st.in_range) begin
                cmd.set_status = 1'b1;
                cmd.st_code    = ihpq_pkg::ST_RANGE;
              end else if (!st.id_valid) begin
                cmd.set_status = 1'b1;
                cmd.st_code    = ihpq_pkg::ST_ABSENT;
              end else begin
                state_next = S_POS_WAIT;
              end
            end
            default: begin
              state_next = S_FIN;
            end
          endcase
        end
      end
      S_POS_WAIT: begin
        cmd.old_rd = 1'b1;
        state_next = S_OLD_WAIT;
      end
      S_OLD_WAIT: begin
        state_next = st.mov_above ? S_UP_CHK : S_DN_L;
      end
      S_UP_CHK: begin
        if (st.s_zero) begin
          state_next = S_PLACE;
        end else begin
          cmd.up_rd  = 1'b1;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (st.mov_above) begin
          cmd.up_move = 1'b1;
          state_next  = S_UP_CHK;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_FIN;
      end
      S_DN_L: begin
        if (st.l_ok) begin
          cmd.l_rd   = 1'b1;
          state_next = S_DN_LW;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_DN_LW: begin
        cmd.l_cmp = 1'b1;
        if (st.r_ok) begin
          cmd.r_rd   = 1'b1;
          state_next = S_DN_RW;
        end else begin
          state_next = S_DN_DEC;
        end
      end
      S_DN_RW: begin
        cmd.r_cmp  = 1'b1;
        state_next = S_DN_DEC;
      end
      S_DN_DEC: begin
        if (st.best_child) begin
          cmd.dn_move = 1'b1;
          state_next  = S_DN_L;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_TOP_PK: begin
        cmd.top_take = 1'b1;
        state_next   = S_FIN;
      end
      S_TOP_EX: begin
        cmd.top_take = 1'b1;
        cmd.extract  = 1'b1;
        state_next   = st.count_one ? S_FIN : S_EX_LAST;
      end
      S_EX_LAST: begin
        cmd.last_take = 1'b1;
        state_next    = S_DN_L;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/indexed_heap_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// indexed_heap_priority_queue_top
// Indexed binary heap priority queue (min or max) with an id-to-slot map.
// ----------------------------------------------------------------------------
//
//  channel   signals                                        handshake
//  --------  ---------------------------------------------  -----------------
//  request   func, item_id, in_priority                     in_valid/in_stall
//  result    status, out_id, out_priority, present, count   out_valid/out_stall
//  mode reg  min_mode                                       cfg_valid/cfg_ready
//
//  One operation at a time. Sift-up reads and compares the parent at each
//  level; sift-down reads the left child, then the right child if there is
//  one, then decides, as the slot RAM has a single read port; a worst case
//  update or extract moves the item through 6 levels.
//  Reset: synchronous; clears count, valid bits and mode (min) at once.
//  A stalled result is held in the output register; the next request is
//  taken as soon as the sequencer returns to idle.
//
module indexed_heap_priority_queue_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ihpq_pkg::FUNC_W-1:0]        func,
  input  logic [ihpq_pkg::ID_W-1:0]          item_id,
  input  logic signed [ihpq_pkg::PRI_W-1:0]  in_priority,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         status,
  output logic [ihpq_pkg::ID_W-1:0]          out_id,
  output logic signed [ihpq_pkg::PRI_W-1:0]  out_priority,
  output logic                               present,
  output logic [ihpq_pkg::CNT_W-1:0]         count,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               min_mode
);

  ihpq_pkg::cmd_t  cmd;
  ihpq_pkg::stat_t st;
  logic            idle;

  // requests and mode writes are taken only by the idle sequencer
  assign in_stall  = !idle;
  assign cfg_ready = idle;

  ihpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .func     (func),
    .st       (st),
    .cmd      (cmd),
    .idle     (idle)
  );

  ihpq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .item_id      (item_id),
    .in_priority  (in_priority),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_mode     (min_mode),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .status       (status),
    .out_id       (out_id),
    .out_priority (out_priority),
    .present      (present),
    .count        (count)
  );

endmodule

// ===== src/ihpq_checker.sv =====
// ----------------------------------------------------------------------------
// ihpq_checker
// Port-level checks on the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module ihpq_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [2:0]                         status,
  input logic [ihpq_pkg::ID_W-1:0]          out_id,
  input logic signed [ihpq_pkg::PRI_W-1:0]  out_priority,
  input logic [ihpq_pkg::CNT_W-1:0]         count,
  input logic                               cfg_ready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(count))
    else $error("stalled transaction changed");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(count) <= ihpq_pkg::CAPACITY)
    else $error("count beyond capacity");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ihpq_pkg::ST_FULL |-> 32'(count) == ihpq_pkg::CAPACITY)
    else $error("full status with room left");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ihpq_pkg::ST_EMPTY |-> count == '0 && out_id == '0
      && out_priority == '0)
    else $error("empty status with entries or data");

  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !in_stall)
    else $error("mode write open while busy");

endmodule

bind indexed_heap_priority_queue_top ihpq_checker u_ihpq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .out_id       (out_id),
  .out_priority (out_priority),
  .count        (count),
  .cfg_ready    (cfg_ready)
);
